// ----- hw/rtl/dsi_pkg.sv -----
// Shared types and constants for the decimal string to int64 converter.
`timescale 1ns / 1ps

package dsi_pkg;

  // ASCII codes that the front end recognizes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  // Largest exponent that can still give a valid result, and the saturation point.
  localparam logic [4:0] EXP_MAX = 5'd18;
  localparam logic [4:0] EXP_SAT = 5'd19;

  // Magnitude limit of the mantissa (2^63), held wide enough for the x10 + d sum.
  localparam logic [67:0] MANT_LIMIT = 68'h0_8000_0000_0000_0000;

  // Largest magnitude that can be multiplied by ten without leaving int64.
  localparam logic [63:0] SCALE_LIMIT = 64'd922337203685477580;

  // Token operations passed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MANT_NEG,
    OP_EXP_NEG,
    OP_MANT_DIGIT,
    OP_EXP_DIGIT,
    OP_JUNK
  } dsi_op_t;

  // One classified character, plus end-of-string information.
  typedef struct packed {
    dsi_op_t    op;
    logic [3:0] digit;
    logic       last;
    logic       empty;
  } dsi_tok_t;

endpackage

// ----- hw/rtl/dsi_front.sv -----
// Front end: accepts characters, tracks field position and classifies each word.
`timescale 1ns / 1ps

module dsi_front
  import dsi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_char_code,
  input  logic       in_char_present,
  input  logic       in_last,
  input  logic       queue_full,
  output logic       push,
  output dsi_tok_t   push_tok
);

  logic in_exp_r, in_exp_nxt;
  logic field_start_r, field_start_nxt;
  logic any_seen_r, any_seen_nxt;
  logic accept;
  logic is_digit;
  logic is_e;
  dsi_op_t op;

  assign accept   = in_valid && !queue_full;
  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign is_e     = (in_char_code == CH_E_LO) || (in_char_code == CH_E_UP);

  // Classify the character against the current field position.
  always_comb begin
    op              = OP_NONE;
    in_exp_nxt      = in_exp_r;
    field_start_nxt = field_start_r;
    any_seen_nxt    = any_seen_r;
    if (in_char_present) begin
      any_seen_nxt    = 1'b1;
      field_start_nxt = 1'b0;
      priority if (field_start_r && (in_char_code == CH_PLUS)) begin
        op = OP_NONE;
      end else if (field_start_r && (in_char_code == CH_MINUS)) begin
        op = in_exp_r ? OP_EXP_NEG : OP_MANT_NEG;
      end else if (is_digit) begin
        op = in_exp_r ? OP_EXP_DIGIT : OP_MANT_DIGIT;
      end else if (!in_exp_r && is_e) begin
        op              = OP_NONE;
        in_exp_nxt      = 1'b1;
        field_start_nxt = 1'b1;
      end else begin
        op = OP_JUNK;
      end
    end
    // The end of a string returns the parser to its start state.
    if (in_last) begin
      in_exp_nxt      = 1'b0;
      field_start_nxt = 1'b1;
      any_seen_nxt    = 1'b0;
    end
  end

  // Only words that change the back end state or end a string are queued.
  assign push           = accept && ((op != OP_NONE) || in_last);
  assign push_tok.op    = op;
  assign push_tok.digit = in_char_code[3:0];
  assign push_tok.last  = in_last;
  assign push_tok.empty = !(any_seen_r || in_char_present);

  // Parser position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_exp_r      <= 1'b0;
      field_start_r <= 1'b1;
      any_seen_r    <= 1'b0;
    end else if (accept) begin
      in_exp_r      <= in_exp_nxt;
      field_start_r <= field_start_nxt;
      any_seen_r    <= any_seen_nxt;
    end
  end

endmodule

// ----- hw/rtl/dsi_queue.sv -----
// Small token queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module dsi_queue
  import dsi_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  dsi_tok_t push_tok,
  output logic     full,
  input  logic     pop,
  output dsi_tok_t pop_tok,
  output logic     not_empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dsi_tok_t        mem_r [DEPTH];
  logic [IW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_tok   = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count exceeds its depth");

endmodule

// ----- hw/rtl/dsi_back.sv -----
// Back end: accumulates mantissa and exponent, scales by ten and holds the result word.
`timescale 1ns / 1ps

module dsi_back
  import dsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  input  dsi_tok_t           tok,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic               out_error
);

  // Accumulator state.
  logic        mneg_r, mneg_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic        eneg_r, eneg_nxt;
  logic [4:0]  exp_r, exp_nxt;
  logic        err_r, err_nxt;

  // Scaler state.
  logic        s_busy_r, s_busy_nxt;
  logic [4:0]  s_cnt_r, s_cnt_nxt;
  logic [63:0] s_mag_r, s_mag_nxt;
  logic        s_neg_r, s_neg_nxt;
  logic        s_err_r, s_err_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_value_r;
  logic               out_error_r;

  logic [67:0] mant_sum;
  logic [7:0]  exp_sum;
  logic        out_free;
  logic        s_done;
  logic        s_free;
  logic        load;
  logic        fin_err;

  assign out_free = !out_valid_r || !out_stall;
  assign s_done   = s_busy_r && (s_cnt_r == '0) && out_free;
  assign s_free   = !s_busy_r || s_done;
  assign pop      = tok_valid && (!tok.last || s_free);
  assign load     = pop && tok.last;

  assign mant_sum = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + {64'b0, tok.digit};
  assign exp_sum  = ({3'b0, exp_r} << 3) + ({3'b0, exp_r} << 1) + {4'b0, tok.digit};

  // Apply one token to the accumulator.
  always_comb begin
    mneg_nxt = mneg_r;
    mag_nxt  = mag_r;
    eneg_nxt = eneg_r;
    exp_nxt  = exp_r;
    err_nxt  = err_r;
    unique case (tok.op)
      OP_MANT_NEG: mneg_nxt = 1'b1;
      OP_EXP_NEG:  eneg_nxt = 1'b1;
      OP_MANT_DIGIT: begin
        if (mant_sum > MANT_LIMIT) begin
          err_nxt = 1'b1;
        end else begin
          mag_nxt = mant_sum[63:0];
        end
      end
      OP_EXP_DIGIT: begin
        exp_nxt = (exp_sum > {3'b0, EXP_SAT}) ? EXP_SAT : exp_sum[4:0];
      end
      OP_JUNK:     err_nxt = 1'b1;
      default:     ;
    endcase
  end

  // Range checks made when a string ends.
  assign fin_err = err_nxt || tok.empty || (!mneg_nxt && mag_nxt[63]) ||
                   (exp_nxt > EXP_MAX) || (eneg_nxt && (exp_nxt != '0));

  always_ff @(posedge clk) begin
    if (!rst_n || load) begin
      mneg_r <= 1'b0;
      mag_r  <= '0;
      eneg_r <= 1'b0;
      exp_r  <= '0;
      err_r  <= 1'b0;
    end else if (pop) begin
      mneg_r <= mneg_nxt;
      mag_r  <= mag_nxt;
      eneg_r <= eneg_nxt;
      exp_r  <= exp_nxt;
      err_r  <= err_nxt;
    end
  end

  // Scaler: one multiply by ten per cycle with an exact overflow check.
  always_comb begin
    s_busy_nxt = s_busy_r;
    s_cnt_nxt  = s_cnt_r;
    s_mag_nxt  = s_mag_r;
    s_neg_nxt  = s_neg_r;
    s_err_nxt  = s_err_r;
    if (s_busy_r && (s_cnt_r != '0)) begin
      if (s_mag_r > SCALE_LIMIT) begin
        s_err_nxt = 1'b1;
        s_cnt_nxt = '0;
      end else begin
        s_mag_nxt = (s_mag_r << 3) + (s_mag_r << 1);
        s_cnt_nxt = s_cnt_r - 1'b1;
      end
    end
    if (s_done) begin
      s_busy_nxt = 1'b0;
    end
    if (load) begin
      s_busy_nxt = 1'b1;
      s_cnt_nxt  = fin_err ? 5'd0 : exp_nxt;
      s_mag_nxt  = mag_nxt;
      s_neg_nxt  = mneg_nxt;
      s_err_nxt  = fin_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_busy_r <= 1'b0;
      s_cnt_r  <= '0;
      s_err_r  <= 1'b0;
    end else begin
      s_busy_r <= s_busy_nxt;
      s_cnt_r  <= s_cnt_nxt;
      s_err_r  <= s_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_mag_r <= s_mag_nxt;
    s_neg_r <= s_neg_nxt;
  end

  // Result word register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_done) begin
      out_error_r <= s_err_r;
      if (s_err_r) begin
        out_value_r <= '0;
      end else begin
        out_value_r <= s_neg_r ? (64'sd0 - $signed(s_mag_r)) : $signed(s_mag_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_error_r |-> out_value_r == 64'sd0)
    else $error("error word carries a nonzero value");

  a_scale_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s_busy_r && (s_cnt_r != '0) |=> s_busy_r)
    else $error("scaler released before its count ran out");

  a_err_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    s_busy_r && s_err_r |-> s_cnt_r == '0)
    else $error("scaler still counting on an error");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s_busy_r |-> s_cnt_r <= EXP_MAX)
    else $error("scaler count above the exponent limit");

endmodule

// ----- hw/rtl/decimal_exponent_string_to_int64_core.sv -----
// Top level of the streaming decimal string to int64 converter.
`timescale 1ns / 1ps

// Usage:
//   The input channel carries one word per character: in_char_code, a flag
//   in_char_present (0 for a bare end marker) and in_last, which ends the string.
//   Exactly one result word (out_value, out_error) follows each word with
//   in_last set; other words give none. Both channels use valid and stall.
//   Throughput: the front end takes one word per cycle while the token queue
//   has room. The back end applies one token per cycle, but an end token waits
//   while the scaler is busy; a string end loads the scaler, which multiplies
//   by ten once per unit of exponent value (exponent at most 18) and then
//   writes the result once the output register is free. A string already
//   in error skips the scaling, and an overflow found while scaling ends it
//   early.
//   Characters of the next string keep flowing into the accumulator while
//   the scaler works; only the next end word waits for it.
//   Reset (rst_n low, synchronous) empties the queue, clears the parser and
//   drops any pending result. When the receiver stalls, the result stays in
//   the output register, the scaler and then the queue fill, and in_stall
//   rises once the queue is full.

module decimal_exponent_string_to_int64_core
  import dsi_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_char_present,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic               out_error
);

  logic     queue_full;
  logic     push;
  dsi_tok_t push_tok;
  logic     pop;
  dsi_tok_t pop_tok;
  logic     not_empty;

  assign in_stall = queue_full;

  // Character classification.
  dsi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_char_code    (in_char_code),
    .in_char_present (in_char_present),
    .in_last         (in_last),
    .queue_full      (queue_full),
    .push            (push),
    .push_tok        (push_tok)
  );

  // Token queue between the two halves.
  dsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (push_tok),
    .full      (queue_full),
    .pop       (pop),
    .pop_tok   (pop_tok),
    .not_empty (not_empty)
  );

  // Accumulation, scaling and result register.
  dsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (not_empty),
    .tok       (pop_tok),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_error (out_error)
  );

endmodule
